/* design/cpss_pkg.sv */
package cpss_pkg;

	localparam int COORD_BITS_DEF = 24;

	// Most result items one vertex can produce (the closing vertex).
	localparam int MAX_RES = 5;
	localparam int CNT_W = $clog2(MAX_RES + 1);

	typedef struct packed {
		logic is_mid;
		logic eoc;
		logic shortc;
	} cpss_flags_t;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_RUN
	} cpss_phase_t;

endpackage

/* design/cpss_front.sv */
module cpss_front #(
	parameter int COORD_BITS = cpss_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [COORD_BITS-1:0]         vertex_x,
	input  logic signed [COORD_BITS-1:0]         vertex_y,
	input  logic                                 last_vertex,
	output logic                                 bnd_valid,
	input  logic                                 bnd_ready,
	output logic [cpss_pkg::CNT_W-1:0]           bnd_cnt,
	output logic signed [COORD_BITS+1:0]         bnd_x   [cpss_pkg::MAX_RES],
	output logic signed [COORD_BITS+1:0]         bnd_y   [cpss_pkg::MAX_RES],
	output cpss_pkg::cpss_flags_t                bnd_flg [cpss_pkg::MAX_RES]
);

	localparam int W = COORD_BITS;
	localparam int CW = cpss_pkg::CNT_W;

	logic                vld_s1;
	logic signed [W-1:0] vx_s1, vy_s1;
	logic                last_s1;

	logic signed [W-1:0] first_x_q, first_y_q;
	logic signed [W-1:0] prior_x_q, prior_y_q;
	logic signed [W-1:0] pmid_x_q, pmid_y_q;
	logic signed [W-1:0] fmid_x_q, fmid_y_q;

	cpss_pkg::cpss_phase_t ph_q, ph_d;

	logic signed [W-1:0] mx, my, cx, cy;
	logic signed [W+1:0] tmx, tmy;
	logic                short_c;
	logic                xfer;

	// floor((a + b) / 2)
	function automatic logic signed [W-1:0] half(input logic signed [W-1:0] a,
	                                             input logic signed [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		return s[W:1];
	endfunction

	function automatic logic signed [W+1:0] sum3(input logic signed [W-1:0] a,
	                                             input logic signed [W-1:0] b,
	                                             input logic signed [W-1:0] c);
		return {{2{a[W-1]}}, a} + {{2{b[W-1]}}, b} + {{2{c[W-1]}}, c};
	endfunction

	assign xfer      = vld_s1 && ((bnd_cnt == '0) || bnd_ready);
	assign bnd_valid = vld_s1 && (bnd_cnt != '0);
	assign in_stall  = vld_s1 && !xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			vx_s1   <= vertex_x;
			vy_s1   <= vertex_y;
			last_s1 <= last_vertex;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= cpss_pkg::PH_FIRST;
		end else if (xfer) begin
			ph_q <= ph_d;
		end
	end

	always_comb begin
		// Midpoint of the edge into this vertex, and of the closing edge.
		mx  = half(prior_x_q, vx_s1);
		my  = half(prior_y_q, vy_s1);
		cx  = half(vx_s1, first_x_q);
		cy  = half(vy_s1, first_y_q);
		tmx = sum3(mx, mx, mx);
		tmy = sum3(my, my, my);

		short_c = last_s1 && (ph_q != cpss_pkg::PH_RUN);
		ph_d    = ph_q;
		bnd_cnt = '0;

		unique case (ph_q)
			cpss_pkg::PH_FIRST: begin
				bnd_cnt = short_c ? CW'(1) : CW'(0);
				ph_d    = last_s1 ? cpss_pkg::PH_FIRST : cpss_pkg::PH_SECOND;
			end
			cpss_pkg::PH_SECOND: begin
				bnd_cnt = CW'(1);
				ph_d    = last_s1 ? cpss_pkg::PH_FIRST : cpss_pkg::PH_RUN;
			end
			cpss_pkg::PH_RUN: begin
				bnd_cnt = last_s1 ? CW'(cpss_pkg::MAX_RES) : CW'(2);
				ph_d    = last_s1 ? cpss_pkg::PH_FIRST : cpss_pkg::PH_RUN;
			end
			default: begin
				ph_d = cpss_pkg::PH_FIRST;
			end
		endcase

		// Each point but the short-contour zero is a sum of three terms; a midpoint is itself taken three times.
		if (short_c) begin
			bnd_x[0] = '0;
			bnd_y[0] = '0;
		end else if (ph_q == cpss_pkg::PH_SECOND) begin
			bnd_x[0] = tmx;
			bnd_y[0] = tmy;
		end else begin
			bnd_x[0] = sum3(pmid_x_q, prior_x_q, mx);
			bnd_y[0] = sum3(pmid_y_q, prior_y_q, my);
		end
		bnd_x[1] = tmx;
		bnd_y[1] = tmy;
		bnd_x[2] = sum3(mx, vx_s1, cx);
		bnd_y[2] = sum3(my, vy_s1, cy);
		bnd_x[3] = sum3(cx, cx, cx);
		bnd_y[3] = sum3(cy, cy, cy);
		bnd_x[4] = sum3(cx, first_x_q, fmid_x_q);
		bnd_y[4] = sum3(cy, first_y_q, fmid_y_q);

		bnd_flg[0].is_mid = (ph_q == cpss_pkg::PH_SECOND) && !short_c;
		bnd_flg[0].eoc    = short_c;
		bnd_flg[0].shortc = short_c;
		bnd_flg[1]        = '{is_mid: 1'b1, eoc: 1'b0, shortc: 1'b0};
		bnd_flg[2]        = '{is_mid: 1'b0, eoc: 1'b0, shortc: 1'b0};
		bnd_flg[3]        = '{is_mid: 1'b1, eoc: 1'b0, shortc: 1'b0};
		bnd_flg[4]        = '{is_mid: 1'b0, eoc: 1'b1, shortc: 1'b0};
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			unique case (ph_q)
				cpss_pkg::PH_FIRST: begin
					first_x_q <= vx_s1;
					first_y_q <= vy_s1;
					prior_x_q <= vx_s1;
					prior_y_q <= vy_s1;
				end
				cpss_pkg::PH_SECOND: begin
					prior_x_q <= vx_s1;
					prior_y_q <= vy_s1;
					pmid_x_q  <= mx;
					pmid_y_q  <= my;
					fmid_x_q  <= mx;
					fmid_y_q  <= my;
				end
				cpss_pkg::PH_RUN: begin
					prior_x_q <= vx_s1;
					prior_y_q <= vy_s1;
					pmid_x_q  <= mx;
					pmid_y_q  <= my;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* design/cpss_seq.sv */
module cpss_seq #(
	parameter int COORD_BITS = cpss_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         bnd_valid,
	output logic                         bnd_ready,
	input  logic [cpss_pkg::CNT_W-1:0]   bnd_cnt,
	input  logic signed [COORD_BITS+1:0] bnd_x   [cpss_pkg::MAX_RES],
	input  logic signed [COORD_BITS+1:0] bnd_y   [cpss_pkg::MAX_RES],
	input  cpss_pkg::cpss_flags_t        bnd_flg [cpss_pkg::MAX_RES],
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic signed [COORD_BITS+1:0] res_x,
	output logic signed [COORD_BITS+1:0] res_y,
	output cpss_pkg::cpss_flags_t        res_flg
);

	localparam int W  = COORD_BITS;
	localparam int CW = cpss_pkg::CNT_W;
	localparam int NR = cpss_pkg::MAX_RES;

	logic [CW-1:0]         cnt_q;
	logic signed [W+1:0]   slot_x_q   [NR];
	logic signed [W+1:0]   slot_y_q   [NR];
	cpss_pkg::cpss_flags_t slot_flg_q [NR];
	logic                  take, load;

	assign take      = (cnt_q != '0) && !res_stall;
	assign bnd_ready = (cnt_q == '0) || ((cnt_q == CW'(1)) && !res_stall);
	assign load      = bnd_valid && bnd_ready;

	assign res_valid = (cnt_q != '0);
	assign res_x     = slot_x_q[0];
	assign res_y     = slot_y_q[0];
	assign res_flg   = slot_flg_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= bnd_cnt;
		end else if (take) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// Slot 0 faces the divider; advance the rest toward it one item per beat while the divider does not stall.
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NR; i++) begin
				slot_x_q[i]   <= bnd_x[i];
				slot_y_q[i]   <= bnd_y[i];
				slot_flg_q[i] <= bnd_flg[i];
			end
		end else if (take) begin
			for (int i = 0; i < NR - 1; i++) begin
				slot_x_q[i]   <= slot_x_q[i+1];
				slot_y_q[i]   <= slot_y_q[i+1];
				slot_flg_q[i] <= slot_flg_q[i+1];
			end
		end
	end

endmodule

/* design/cpss_div3.sv */
module cpss_div3 #(
	parameter int COORD_BITS = cpss_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS+1:0] in_x,
	input  logic signed [COORD_BITS+1:0] in_y,
	input  cpss_pkg::cpss_flags_t        in_flg,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output cpss_pkg::cpss_flags_t        out_flg
);

	localparam int W  = COORD_BITS;
	localparam int AW = W + 2;
	localparam int MW = W + 1;
	localparam int PW = 2 * W + 2;
	// ceil(2^AW / 3): any magnitude below 2^MW times this, shifted right by AW,
	// is the exact quotient.
	localparam logic [MW-1:0] RECIP = MW'(((64'd1 << AW) + 64'd2) / 64'd3);

	logic                  rdy;
	logic [AW-1:0]         absx, absy;
	logic [PW-1:0]         prodx, prody;
	logic [W-1:0]          magx, magy;
	logic [W-1:0]          qx, qy;

	logic                  ovld_q;
	logic signed [W-1:0]   ox_q, oy_q;
	cpss_pkg::cpss_flags_t oflg_q;

	assign rdy      = !ovld_q || !out_stall;
	assign in_stall = !rdy;

	assign absx = in_x[AW-1] ? (~in_x + AW'(1)) : in_x;
	assign absy = in_y[AW-1] ? (~in_y + AW'(1)) : in_y;

	// Quotient of the magnitude, then restore the sign: truncation toward zero.
	assign prodx = PW'(absx[MW-1:0]) * PW'(RECIP);
	assign prody = PW'(absy[MW-1:0]) * PW'(RECIP);
	assign magx  = prodx[PW-1:AW];
	assign magy  = prody[PW-1:AW];
	assign qx    = in_x[AW-1] ? (~magx + W'(1)) : magx;
	assign qy    = in_y[AW-1] ? (~magy + W'(1)) : magy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (rdy) begin
			ovld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && in_valid) begin
			ox_q   <= qx;
			oy_q   <= qy;
			oflg_q <= in_flg;
		end
	end

	assign out_valid = ovld_q;
	assign out_x     = ox_q;
	assign out_y     = oy_q;
	assign out_flg   = oflg_q;

endmodule

/* design/closed_polygon_subdivide_smooth.sv */
// One level of midpoint subdivision with vertex smoothing on a closed polygon, signed Q16.8.
// Input channel (in_valid / in_stall): one vertex per item, last_vertex set
// on the final vertex of a contour. Output channel (out_valid / out_stall):
// one point per item, in the order m0, s1, m1, ..., s(n-1), m(n-1), s0;
// s0 carries end_of_contour. A contour of one or two vertices yields a
// single item with short_contour and end_of_contour set and a zero point.
// Throughput: one vertex per cycle into the input register while in_stall is
// low; the result sequencer then sends one point per cycle unless the divider
// stalls, so a middle vertex yields 2 points, the second vertex 1, the closing
// vertex 5; the first vertex yields no point and a short contour 1.
// The output port of the sequencer is what sets this rate.
// The first point of an item is registered in the sequencer, then passes
// through the divide-by-three into the output register.
// Reset clears all valid flags and the contour phase; the next vertex
// starts a new contour. A stalled receiver holds the output item; the
// stall backs up through the pipeline and reaches in_stall once the
// input register is full.
module closed_polygon_subdivide_smooth #(
	parameter int COORD_BITS = cpss_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] vertex_x,
	input  logic signed [COORD_BITS-1:0] vertex_y,
	input  logic                         last_vertex,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y,
	output logic                         is_midpoint,
	output logic                         end_of_contour,
	output logic                         short_contour
);

	logic                         bnd_valid, bnd_ready;
	logic [cpss_pkg::CNT_W-1:0]   bnd_cnt;
	logic signed [COORD_BITS+1:0] bnd_x   [cpss_pkg::MAX_RES];
	logic signed [COORD_BITS+1:0] bnd_y   [cpss_pkg::MAX_RES];
	cpss_pkg::cpss_flags_t        bnd_flg [cpss_pkg::MAX_RES];

	logic                         res_valid, res_stall;
	logic signed [COORD_BITS+1:0] res_x, res_y;
	cpss_pkg::cpss_flags_t        res_flg;
	cpss_pkg::cpss_flags_t        out_flg;

	cpss_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.last_vertex (last_vertex),
		.bnd_valid   (bnd_valid),
		.bnd_ready   (bnd_ready),
		.bnd_cnt     (bnd_cnt),
		.bnd_x       (bnd_x),
		.bnd_y       (bnd_y),
		.bnd_flg     (bnd_flg)
	);

	cpss_seq #(.COORD_BITS(COORD_BITS)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.bnd_valid (bnd_valid),
		.bnd_ready (bnd_ready),
		.bnd_cnt   (bnd_cnt),
		.bnd_x     (bnd_x),
		.bnd_y     (bnd_y),
		.bnd_flg   (bnd_flg),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_x     (res_x),
		.res_y     (res_y),
		.res_flg   (res_flg)
	);

	cpss_div3 #(.COORD_BITS(COORD_BITS)) u_div3 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_stall  (res_stall),
		.in_x      (res_x),
		.in_y      (res_y),
		.in_flg    (res_flg),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_x     (point_x),
		.out_y     (point_y),
		.out_flg   (out_flg)
	);

	assign is_midpoint    = out_flg.is_mid;
	assign end_of_contour = out_flg.eoc;
	assign short_contour  = out_flg.shortc;

endmodule

/* design/cpss_chk.sv */
module cpss_chk #(
	parameter int COORD_BITS = cpss_pkg::COORD_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic signed [COORD_BITS-1:0] point_x,
	input logic signed [COORD_BITS-1:0] point_y,
	input logic                         is_midpoint,
	input logic                         end_of_contour,
	input logic                         short_contour
);

	// A short contour item is the whole contour: closed, empty, at the origin.
	a_short_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && short_contour |->
			end_of_contour && !is_midpoint && point_x == '0 && point_y == '0)
		else $error("short contour item malformed");

	// The contour never closes on a midpoint: a short one closes on its zero item, any other on a smoothed vertex.
	a_end_not_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_midpoint |-> !end_of_contour)
		else $error("midpoint flagged as end of contour");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			out_valid && $stable(point_x) && $stable(point_y) &&
			$stable(is_midpoint) && $stable(end_of_contour))
		else $error("stalled output item changed");

endmodule

bind closed_polygon_subdivide_smooth cpss_chk #(.COORD_BITS(COORD_BITS)) u_cpss_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.point_x        (point_x),
	.point_y        (point_y),
	.is_midpoint    (is_midpoint),
	.end_of_contour (end_of_contour),
	.short_contour  (short_contour)
);
